@@ hw/rtl/bclp_pkg.sv @@
package bclp_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;
   localparam int NOW_WIDTH          = 32;
   localparam int CFG_WIDTH          = 16;
   localparam int CSR_INDEX_WIDTH    = 2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEBOUNCE   = 2'd0,
      CSR_LONG_PRESS = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_time;
      logic [CFG_WIDTH-1:0] long_press_time;
   } cfg_type;

   typedef struct packed {
      logic                 button_level;
      logic [NOW_WIDTH-1:0] now_ms;
      logic                 ack_short;
      logic                 ack_long;
   } sample_type;

   typedef struct packed {
      logic short_click;
      logic long_click;
   } flags_type;

endpackage

@@ hw/rtl/bclp_req_if.sv @@
interface bclp_req_if;
   logic                           valid;
   logic                           ready;
   logic                           button_level;
   logic [bclp_pkg::NOW_WIDTH-1:0] now_ms;
   logic                           ack_short;
   logic                           ack_long;

   modport source (output valid, output button_level, output now_ms,
                   output ack_short, output ack_long, input ready);
   modport sink   (input valid, input button_level, input now_ms,
                   input ack_short, input ack_long, output ready);
endinterface

@@ hw/rtl/bclp_rsp_if.sv @@
interface bclp_rsp_if;
   logic valid;
   logic ready;
   logic short_click;
   logic long_click;

   modport source (output valid, output short_click, output long_click, input ready);
   modport sink   (input valid, input short_click, input long_click, output ready);
endinterface

@@ hw/rtl/button_click_long_press_classifier.sv @@
// Two register stages: an accepted item is held in stage 1, then moves to
// the result register, which drives rsp_bus.
// Throughput: 1 item per cycle while rsp_bus is ready; each of the two
// registers holds one item, so req_bus takes one more while a result waits.
// Reset (synchronous, active high) empties both stages, loads debounce 50 ms
// and long press 1000 ms, marks the button released and clears both flags.
module button_click_long_press_classifier #(
   parameter int TIME_WIDTH = bclp_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bclp_req_if.sink                             req_bus,
   bclp_rsp_if.source                           rsp_bus,
   input  logic                                 csr_we,
   input  logic [bclp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bclp_pkg::CFG_WIDTH-1:0]       csr_wdata
);

   bclp_pkg::cfg_type    cfg_ff, cfg_in;
   logic                 s1_valid_ff, s1_valid_in;
   bclp_pkg::sample_type s1_sample_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   bclp_pkg::flags_type  rsp_flags_ff;
   bclp_pkg::flags_type  flags;
   logic                 req_fire;
   logic                 rsp_fire;
   logic                 advance;

   // configuration decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (bclp_pkg::csr_index_type'(csr_index))
            bclp_pkg::CSR_DEBOUNCE:   cfg_in.debounce_time   = csr_wdata;
            bclp_pkg::CSR_LONG_PRESS: cfg_in.long_press_time = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= bclp_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_time <= bclp_pkg::LONG_PRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage 1 hands its item to the result register when that slot frees up
   assign rsp_fire      = rsp_valid_ff && rsp_bus.ready;
   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sample_ff.button_level <= req_bus.button_level;
         s1_sample_ff.now_ms       <= req_bus.now_ms;
         s1_sample_ff.ack_short    <= req_bus.ack_short;
         s1_sample_ff.ack_long     <= req_bus.ack_long;
      end
      if (advance) begin
         rsp_flags_ff <= flags;
      end
   end

   bclp_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .sample (s1_sample_ff),
      .cfg    (cfg_ff),
      .flags  (flags)
   );

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.short_click = rsp_flags_ff.short_click;
   assign rsp_bus.long_click  = rsp_flags_ff.long_click;

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted item lost from stage 1");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_sample_ff))
      else $error("stalled stage 1 item changed");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item did not reach result register");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !advance |=> !rsp_valid_ff)
      else $error("result repeated after being taken");
`endif

endmodule

@@ hw/rtl/bclp_core.sv @@
module bclp_core #(
   parameter int TIME_WIDTH = bclp_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  bclp_pkg::sample_type sample,
   input  bclp_pkg::cfg_type    cfg,
   output bclp_pkg::flags_type  flags
);

   logic                  prev_level_ff, prev_level_in;
   logic [TIME_WIDTH-1:0] last_edge_ff, last_edge_in;
   logic [TIME_WIDTH-1:0] press_start_ff, press_start_in;
   logic                  short_ff, short_in;
   logic                  long_ff, long_in;

   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] since_edge;
   logic [TIME_WIDTH-1:0] held_for;
   logic                  settled;
   logic                  fall;
   logic                  rise;
   logic                  long_hit;
   logic                  short_new;
   logic                  long_new;

   // time arithmetic wraps at TIME_WIDTH bits
   assign now_t      = TIME_WIDTH'(sample.now_ms);
   assign since_edge = now_t - last_edge_ff;
   assign held_for   = now_t - press_start_ff;
   assign settled    = since_edge > TIME_WIDTH'(cfg.debounce_time);
   assign long_hit   = held_for >= TIME_WIDTH'(cfg.long_press_time);

   assign fall = !sample.button_level &&  prev_level_ff && settled;
   assign rise =  sample.button_level && !prev_level_ff && settled;

   assign short_new = short_ff | (rise & !long_hit);
   assign long_new  = long_ff  | (rise &  long_hit);

   // report before the acknowledge clears
   assign flags.short_click = short_new;
   assign flags.long_click  = long_new;

   always_comb begin
      prev_level_in  = prev_level_ff;
      last_edge_in   = last_edge_ff;
      press_start_in = press_start_ff;
      short_in       = short_ff;
      long_in        = long_ff;
      if (step) begin
         prev_level_in = sample.button_level;
         if (fall) begin
            press_start_in = now_t;
         end
         if (fall || rise) begin
            last_edge_in = now_t;
         end
         short_in = short_new & !sample.ack_short;
         long_in  = long_new  & !sample.ack_long;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff  <= 1'b1;
         last_edge_ff   <= '0;
         press_start_ff <= '0;
         short_ff       <= 1'b0;
         long_ff        <= 1'b0;
      end else begin
         prev_level_ff  <= prev_level_in;
         last_edge_ff   <= last_edge_in;
         press_start_ff <= press_start_in;
         short_ff       <= short_in;
         long_ff        <= long_in;
      end
   end

endmodule
